>>> src/td3m_pkg.sv
package td3m_pkg;

    // default volume limits
    localparam int DEF_MAX_X = 256;
    localparam int DEF_MAX_Y = 256;
    localparam int DEF_MAX_Z = 256;

    // neighbourhood reach, fixed by the three-tap structure
    localparam int RADIUS = 1;

    // field widths
    localparam int SIZE_W     = 9;
    localparam int SAMPLE_W   = 16;
    localparam int OUT_DATA_W = 8;

    // apb port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    // register reset values
    localparam int                          SIZE_RESET      = 256;
    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = 16'sd256;

    // register map, word index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_SIZE_X    = 2'd0,
        REG_SIZE_Y    = 2'd1,
        REG_SIZE_Z    = 2'd2,
        REG_THRESHOLD = 2'd3
    } reg_idx_t;

endpackage

>>> src/td3m_ram.sv
module td3m_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/threshold_dilate_3d_mask.sv
// threshold_dilate_3d_mask: 3x3x3 binary dilation of a thresholded voxel stream
//
// s_ channel: one voxel per word in raster order (x fastest, then y, then z);
//   a voxel is foreground when its signed q7.8 sample is above the threshold.
//   s_tuser marks a pad word, which flushes the tail of the volume.
// m_ channel: one mask bit per voxel in raster order, m_tlast on the last voxel.
// apb port: size_x, size_y, size_z, threshold at 0x0, 0x4, 0x8, 0xc. sizes are
//   latched when a volume starts; a write takes effect with the next volume.
// latency: the result of voxel n is loaded into the output register by the word
//   that carries item n + L, with L = size_x*size_y + size_x + 1, and shows on
//   m_ the cycle after. the first L words of a volume give no result, so L pad
//   words follow the last voxel.
// throughput: one word per cycle on both sides; the x, y and z passes each
//   take one tap per word from a two-entry window, a line ram and a plane ram,
//   all read one word ahead.
// reset clears counters, window and the output valid flag; the rams need no
//   clearing, stale entries are masked by the volume edge checks.
// when m_tready is low with a result held, s_tready drops until it is taken.
module threshold_dilate_3d_mask import td3m_pkg::*; #(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y,
    parameter int MAX_Z = DEF_MAX_Z
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
    input  logic [0:0]            s_tuser,   // [0] pad

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [0] mask_bit, [7:1] zero
    output logic                  m_tlast,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_AW-1:0]     paddr,
    input  logic [CFG_DW-1:0]     pwdata,
    output logic [CFG_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int XW          = $clog2(MAX_X);
    localparam int YW          = $clog2(MAX_Y);
    localparam int ZW          = $clog2(MAX_Z + 2);
    localparam int PLANE_AW    = XW + YW;
    localparam int PLANE_DEPTH = 1 << PLANE_AW;
    localparam int SX_RST      = ((SIZE_RESET > MAX_X) ? MAX_X : SIZE_RESET) - 1;
    localparam int SY_RST      = ((SIZE_RESET > MAX_Y) ? MAX_Y : SIZE_RESET) - 1;
    localparam int SZ_RST      = ((SIZE_RESET > MAX_Z) ? MAX_Z : SIZE_RESET) - 1;
    localparam int TAPS        = 2 * RADIUS;

    // ---------------------------------------------------------------- config
    logic [SIZE_W-1:0]          size_x_reg;
    logic [SIZE_W-1:0]          size_y_reg;
    logic [SIZE_W-1:0]          size_z_reg;
    logic signed [SAMPLE_W-1:0] threshold_reg;
    reg_idx_t                   cfg_idx;
    logic                       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg    <= SIZE_W'(SIZE_RESET);
            size_y_reg    <= SIZE_W'(SIZE_RESET);
            size_z_reg    <= SIZE_W'(SIZE_RESET);
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SIZE_X:    size_x_reg    <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y:    size_y_reg    <= pwdata[SIZE_W-1:0];
                REG_SIZE_Z:    size_z_reg    <= pwdata[SIZE_W-1:0];
                REG_THRESHOLD: threshold_reg <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SIZE_X:    prdata = {{(CFG_DW-SIZE_W){1'b0}}, size_x_reg};
            REG_SIZE_Y:    prdata = {{(CFG_DW-SIZE_W){1'b0}}, size_y_reg};
            REG_SIZE_Z:    prdata = {{(CFG_DW-SIZE_W){1'b0}}, size_z_reg};
            REG_THRESHOLD: prdata = {{(CFG_DW-SAMPLE_W){1'b0}}, threshold_reg};
            default:       prdata = '0;
        endcase
    end

    // sizes as last-index values: zero acts as one, above the limit acts as the limit
    logic [XW-1:0] sx_lim;
    logic [YW-1:0] sy_lim;
    logic [ZW-1:0] sz_lim;

    always_comb begin
        if (size_x_reg == '0) begin
            sx_lim = '0;
        end else if (int'(size_x_reg) > MAX_X) begin
            sx_lim = XW'(MAX_X - 1);
        end else begin
            sx_lim = XW'(size_x_reg - 1'b1);
        end
        if (size_y_reg == '0) begin
            sy_lim = '0;
        end else if (int'(size_y_reg) > MAX_Y) begin
            sy_lim = YW'(MAX_Y - 1);
        end else begin
            sy_lim = YW'(size_y_reg - 1'b1);
        end
        if (size_z_reg == '0) begin
            sz_lim = '0;
        end else if (int'(size_z_reg) > MAX_Z) begin
            sz_lim = ZW'(MAX_Z - 1);
        end else begin
            sz_lim = ZW'(size_z_reg - 1'b1);
        end
    end

    // ------------------------------------------------------------- handshake
    logic accept;
    logic fg;
    logic m_valid_reg;
    logic m_mask_reg;
    logic m_last_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    // pad words count as background
    assign fg       = !s_tuser[0] && ($signed(s_tdata) > threshold_reg);

    // ------------------------------------------------------------------ state
    // stage 1 works on voxel k-1 (x pass), stage 2 on k-1-sx (y pass),
    // stage 3 on k-L (z pass), k being the index of the word being taken
    logic          act1_reg, act1_next;
    logic [XW-1:0] sx_m1_reg;
    logic [YW-1:0] sy_m1_reg;
    logic [ZW-1:0] sz_m1_reg;
    logic          f1_reg, f2_reg;

    logic [XW-1:0] x1_reg, x1_next, x2_reg, x2_next, x3_reg, x3_next;
    logic [YW-1:0] y1_reg, y1_next, y2_reg, y2_next, y3_reg, y3_next;
    logic [ZW-1:0] z1_reg, z1_next, z2_reg, z2_next, z3_reg, z3_next;

    logic            act2, act3;
    logic            en1, en2, emit, vol_end;
    logic            a_bit, b_bit, c_bit, c_last;
    logic [TAPS-1:0] line_rd, plane_rd;

    assign act2 = act1_reg && ((y1_reg != '0) || (z1_reg != '0));
    assign act3 = act2 && (z2_reg != '0);
    assign en1  = accept && act1_reg;
    assign en2  = accept && act2;
    assign emit = accept && act3;

    // separable or: x taps from the window, y taps from the line ram,
    // z taps from the plane ram, each masked at the volume edges
    assign a_bit = f1_reg
                 | (f2_reg & (x1_reg != '0))
                 | (fg & (x1_reg != sx_m1_reg));
    assign b_bit = line_rd[0]
                 | (line_rd[1] & (y2_reg != '0))
                 | (a_bit & (y2_reg != sy_m1_reg));
    assign c_bit = plane_rd[0]
                 | (plane_rd[1] & (z3_reg != '0))
                 | (b_bit & (z3_reg != sz_m1_reg));
    assign c_last  = (x3_reg == sx_m1_reg) && (y3_reg == sy_m1_reg)
                  && (z3_reg == sz_m1_reg);
    assign vol_end = emit && c_last;

    // raster counters of the three stages
    always_comb begin
        x1_next   = x1_reg;
        y1_next   = y1_reg;
        z1_next   = z1_reg;
        x2_next   = x2_reg;
        y2_next   = y2_reg;
        z2_next   = z2_reg;
        x3_next   = x3_reg;
        y3_next   = y3_reg;
        z3_next   = z3_reg;
        act1_next = act1_reg || accept;
        if (vol_end) begin
            x1_next   = '0;
            y1_next   = '0;
            z1_next   = '0;
            x2_next   = '0;
            y2_next   = '0;
            z2_next   = '0;
            x3_next   = '0;
            y3_next   = '0;
            z3_next   = '0;
            act1_next = 1'b0;
        end else begin
            if (en1) begin
                if (x1_reg != sx_m1_reg) begin
                    x1_next = x1_reg + 1'b1;
                end else begin
                    x1_next = '0;
                    if (y1_reg != sy_m1_reg) begin
                        y1_next = y1_reg + 1'b1;
                    end else begin
                        y1_next = '0;
                        z1_next = z1_reg + 1'b1;
                    end
                end
            end
            if (en2) begin
                if (x2_reg != sx_m1_reg) begin
                    x2_next = x2_reg + 1'b1;
                end else begin
                    x2_next = '0;
                    if (y2_reg != sy_m1_reg) begin
                        y2_next = y2_reg + 1'b1;
                    end else begin
                        y2_next = '0;
                        z2_next = z2_reg + 1'b1;
                    end
                end
            end
            if (emit) begin
                if (x3_reg != sx_m1_reg) begin
                    x3_next = x3_reg + 1'b1;
                end else begin
                    x3_next = '0;
                    if (y3_reg != sy_m1_reg) begin
                        y3_next = y3_reg + 1'b1;
                    end else begin
                        y3_next = '0;
                        z3_next = z3_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act1_reg  <= 1'b0;
            sx_m1_reg <= XW'(SX_RST);
            sy_m1_reg <= YW'(SY_RST);
            sz_m1_reg <= ZW'(SZ_RST);
            f1_reg    <= 1'b0;
            f2_reg    <= 1'b0;
            x1_reg    <= '0;
            y1_reg    <= '0;
            z1_reg    <= '0;
            x2_reg    <= '0;
            y2_reg    <= '0;
            z2_reg    <= '0;
            x3_reg    <= '0;
            y3_reg    <= '0;
            z3_reg    <= '0;
        end else begin
            act1_reg <= act1_next;
            // sizes latched on the first word of a volume
            if (accept && !act1_reg) begin
                sx_m1_reg <= sx_lim;
                sy_m1_reg <= sy_lim;
                sz_m1_reg <= sz_lim;
            end
            if (accept) begin
                f1_reg <= fg;
                f2_reg <= f1_reg;
            end
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            z1_reg <= z1_next;
            x2_reg <= x2_next;
            y2_reg <= y2_next;
            z2_reg <= z2_next;
            x3_reg <= x3_next;
            y3_reg <= y3_next;
            z3_reg <= z3_next;
        end
    end

    // ------------------------------------------------------------------- rams
    // each entry holds {older tap, newer tap}; reads are issued one word
    // ahead at the next coordinate, with a bypass when it equals the write
    logic [XW-1:0]       line_waddr, line_raddr;
    logic [TAPS-1:0]     line_wdata, line_q, line_wd_reg;
    logic                line_byp_reg;
    logic [PLANE_AW-1:0] plane_waddr, plane_raddr;
    logic [TAPS-1:0]     plane_wdata, plane_q, plane_wd_reg;
    logic                plane_byp_reg;

    assign line_waddr  = x1_reg;
    assign line_raddr  = x1_next;
    assign line_wdata  = {line_rd[0], a_bit};
    assign plane_waddr = {y2_reg, x2_reg};
    assign plane_raddr = {y2_next, x2_next};
    assign plane_wdata = {plane_rd[0], b_bit};

    assign line_rd  = line_byp_reg  ? line_wd_reg  : line_q;
    assign plane_rd = plane_byp_reg ? plane_wd_reg : plane_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_byp_reg  <= 1'b0;
            plane_byp_reg <= 1'b0;
        end else begin
            line_byp_reg  <= en1 && (line_waddr == line_raddr);
            plane_byp_reg <= en2 && (plane_waddr == plane_raddr);
        end
        line_wd_reg  <= line_wdata;
        plane_wd_reg <= plane_wdata;
    end

    td3m_ram #(
        .WIDTH (TAPS),
        .DEPTH (MAX_X)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (en1),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_q)
    );

    td3m_ram #(
        .WIDTH (TAPS),
        .DEPTH (PLANE_DEPTH)
    ) u_plane_ram (
        .aclk  (aclk),
        .we    (en2),
        .waddr (plane_waddr),
        .wdata (plane_wdata),
        .raddr (plane_raddr),
        .rdata (plane_q)
    );

    // -------------------------------------------------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (emit) begin
            m_mask_reg <= c_bit;
            m_last_reg <= c_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, m_mask_reg};
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------- assertions
    a_coords_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (x1_reg <= sx_m1_reg) && (x2_reg <= sx_m1_reg)
        && (x3_reg <= sx_m1_reg) && (y2_reg <= sy_m1_reg) && (y3_reg <= sy_m1_reg))
        else $error("stage coordinate beyond latched size");

    a_z_out_in_volume: assert property (@(posedge aclk) disable iff (!aresetn)
        act3 |-> (z3_reg <= sz_m1_reg))
        else $error("z pass beyond last slice");

    a_volume_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        vol_end |=> (!act1_reg && (z1_reg == '0) && (z2_reg == '0) && (z3_reg == '0)))
        else $error("counters not cleared after last voxel");

    a_size_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !act1_reg) |=> (sx_m1_reg == $past(sx_lim))
        && (sz_m1_reg == $past(sz_lim)))
        else $error("sizes not latched at volume start");

endmodule
